@@ src/pid_controller_step_assert.svh @@
// Assertion macros shared by the PID step block
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pid_controller_step: same-cycle check failed");
// next-cycle implication
`define PS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pid_controller_step: next-cycle check failed");
`else
`define PS_ASSERT_NOW(label, clk, rst, ante, cons)
`define PS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/pid_step_pkg.sv @@
// Package: widths, codes, sequencer states and saturation helpers of the PID step block
package pid_step_pkg;

   localparam int VALUE_W   = 32;
   localparam int TIME_W    = 32;
   localparam int ACC_W     = 48;
   localparam int FRAC_W    = 16;
   localparam int OPND_W    = VALUE_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int MAG_W     = 80;
   localparam int DIV_W     = 64;
   localparam int CNT_W     = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;

   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_OBSERVE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_P_ON_MEAS = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_D_ON_MEAS = CSR_IDX_W'(4);

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b000_0000_0000_0000_0001,
      ST_PREP   = 19'b000_0000_0000_0000_0010,
      ST_ABS    = 19'b000_0000_0000_0000_0100,
      ST_MUL_I  = 19'b000_0000_0000_0000_1000,
      ST_FIN_I  = 19'b000_0000_0000_0001_0000,
      ST_MUL_TL = 19'b000_0000_0000_0010_0000,
      ST_MUL_TH = 19'b000_0000_0000_0100_0000,
      ST_ACC_T  = 19'b000_0000_0000_1000_0000,
      ST_FIN_T  = 19'b000_0000_0001_0000_0000,
      ST_ADD_I  = 19'b000_0000_0010_0000_0000,
      ST_MUL_P  = 19'b000_0000_0100_0000_0000,
      ST_FIN_P  = 19'b000_0000_1000_0000_0000,
      ST_ADD_P  = 19'b000_0001_0000_0000_0000,
      ST_MUL_D  = 19'b000_0010_0000_0000_0000,
      ST_LOAD_D = 19'b000_0100_0000_0000_0000,
      ST_DIV    = 19'b000_1000_0000_0000_0000,
      ST_FIN_D  = 19'b001_0000_0000_0000_0000,
      ST_ADD_D  = 19'b010_0000_0000_0000_0000,
      ST_OUT    = 19'b100_0000_0000_0000_0000
   } state_type;

   typedef struct packed {
      logic             sat;
      logic [ACC_W-1:0] mag;
   } term_type;

   typedef struct packed {
      logic             sat;
      logic [ACC_W-1:0] val;
   } sum_type;

   // Clip a product magnitude to the accumulator range; a negative term may reach 2^(ACC_W-1)
   function automatic term_type fin_term(input logic [MAG_W-1:0] val, input logic neg);
      term_type         r;
      logic [ACC_W-1:0] lim;
      lim = ACC_MAX + {{(ACC_W-1){1'b0}}, neg};
      if ((val[MAG_W-1:ACC_W] != '0) || (val[ACC_W-1:0] > lim)) begin
         r.sat = 1'b1;
         r.mag = lim;
      end else begin
         r.sat = 1'b0;
         r.mag = val[ACC_W-1:0];
      end
      return r;
   endfunction

   // Signed accumulator plus or minus a magnitude, saturated to ACC_W bits
   function automatic sum_type acc_addsub(input logic [ACC_W-1:0] a,
                                          input logic [ACC_W-1:0] mag,
                                          input logic sub);
      sum_type          r;
      logic [ACC_W+1:0] ax;
      logic [ACC_W+1:0] mx;
      logic [ACC_W+1:0] s;
      ax = {{2{a[ACC_W-1]}}, a};
      mx = {2'b00, mag};
      s  = sub ? (ax - mx) : (ax + mx);
      if ((s[ACC_W+1:ACC_W-1] == 3'b000) || (s[ACC_W+1:ACC_W-1] == 3'b111)) begin
         r.sat = 1'b0;
         r.val = s[ACC_W-1:0];
      end else begin
         r.sat = 1'b1;
         r.val = s[ACC_W+1] ? ACC_MIN : ACC_MAX;
      end
      return r;
   endfunction

endpackage

@@ src/pid_controller_step.sv @@
// PID controller step: sequencer around one shared multiplier and a bit-serial divider
//
// Input channel (req_*): one sample per transfer, with an operation, a timestamp in ticks,
// a measurement and a target, all signed Q16.16 except the timestamp. req_stall is high
// whenever the sequencer is busy; an observe sample only updates the history and is done
// in the cycle it is taken.
// Result channel (rsp_*): one drive value and a saturation flag per compute sample.
// A compute sample works out the integral, proportional and derivative terms in turn; the
// derivative term is added only when the time step is positive and is divided by it in
// the 64-step restoring divider, one quotient bit a cycle.
// A new sample is taken only once the sequencer is back in idle after a compute sample;
// observe samples transfer back to back.
// The result sits in an output register: the next sample is taken while it waits. If the
// receiver still stalls when the next result is ready, the sequencer holds in its last
// step until the output register frees.
// Configuration (csr_*): gains and mode bits by index; the user must write them only while
// the block is idle, not enforced. csr_ready is always high, unknown indexes are dropped.
// Reset (synchronous): gains and modes clear, history is marked unseeded, no result pending.

`include "pid_controller_step_assert.svh"

module pid_controller_step (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_operation,
   input  logic signed [pid_step_pkg::TIME_W-1:0]     req_timestamp,
   input  logic signed [pid_step_pkg::VALUE_W-1:0]    req_measurement,
   input  logic signed [pid_step_pkg::VALUE_W-1:0]    req_target,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [pid_step_pkg::VALUE_W-1:0]    rsp_drive,
   output logic                                       rsp_saturated,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [pid_step_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [pid_step_pkg::VALUE_W-1:0]    csr_wdata
);
   import pid_step_pkg::*;

   state_type            state_ff, state_in;
   logic                 primed_ff, primed_in;
   logic [VALUE_W-1:0]   gain_p_ff, gain_p_in;
   logic [VALUE_W-1:0]   gain_i_ff, gain_i_in;
   logic [VALUE_W-1:0]   gain_d_ff, gain_d_in;
   logic                 p_meas_ff, p_meas_in;
   logic                 d_meas_ff, d_meas_in;
   logic [VALUE_W-1:0]   prev_meas_ff, prev_meas_in;
   logic [VALUE_W-1:0]   prev_err_ff, prev_err_in;
   logic [TIME_W-1:0]    prev_time_ff, prev_time_in;
   logic [ACC_W-1:0]     integ_ff, integ_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [VALUE_W-1:0]   meas_ff, meas_in;
   logic [VALUE_W-1:0]   err_ff, err_in;
   logic [TIME_W-1:0]    ts_ff, ts_in;
   logic [VALUE_W:0]     din_ff, din_in;
   logic [VALUE_W:0]     diff_ff, diff_in;
   logic [TIME_W-1:0]    dt_ff, dt_in;
   logic [VALUE_W-1:0]   err_mag_ff, err_mag_in;
   logic [VALUE_W:0]     din_mag_ff, din_mag_in;
   logic [VALUE_W:0]     diff_mag_ff, diff_mag_in;
   logic [TIME_W-1:0]    dt_mag_ff, dt_mag_in;
   logic [VALUE_W-1:0]   gp_mag_ff, gp_mag_in;
   logic [VALUE_W-1:0]   gi_mag_ff, gi_mag_in;
   logic [VALUE_W-1:0]   gd_mag_ff, gd_mag_in;
   logic                 neg_ff, neg_in;
   logic                 tneg_ff, tneg_in;
   logic [ACC_W-1:0]     tmag_ff, tmag_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [TIME_W-2:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ACC_W-1:0]     res_ff, res_in;
   logic                 sat_ff, sat_in;
   logic [VALUE_W-1:0]   rsp_drive_ff, rsp_drive_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                 req_xfer;
   logic [VALUE_W:0]     err_diff;
   logic [VALUE_W-1:0]   err_clip;
   logic [OPND_W-1:0]    mul_a;
   logic [OPND_W-1:0]    mul_b;
   logic [PROD_W-1:0]    mul_out;
   logic [MAG_W-1:0]     fin_val;
   term_type             fin;
   logic [ACC_W-1:0]     add_a;
   logic                 add_sub;
   sum_type              sum;
   logic [TIME_W-1:0]    div_trial;
   logic [TIME_W-1:0]    div_rest;
   logic                 div_ge;
   logic                 dt_pos;
   logic                 res_fits;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

   // error = target - measurement, clipped to the value range without flagging
   assign err_diff = {req_target[VALUE_W-1], req_target}
                   - {req_measurement[VALUE_W-1], req_measurement};
   assign err_clip = (err_diff[VALUE_W] != err_diff[VALUE_W-1])
                   ? (err_diff[VALUE_W] ? VALUE_MIN : VALUE_MAX)
                   : err_diff[VALUE_W-1:0];

   assign dt_pos   = !dt_ff[TIME_W-1] && (dt_ff != '0);
   assign res_fits = (res_ff[ACC_W-1:VALUE_W-1] == '0) || (&res_ff[ACC_W-1:VALUE_W-1]);

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_MUL_I: begin
            mul_a = {1'b0, gi_mag_ff};
            mul_b = {1'b0, err_mag_ff};
         end
         ST_MUL_TL: begin
            mul_a = tmag_ff[OPND_W-1:0];
            mul_b = {1'b0, dt_mag_ff};
         end
         ST_MUL_TH: begin
            mul_a = {{(PROD_W-ACC_W){1'b0}}, tmag_ff[ACC_W-1:OPND_W]};
            mul_b = {1'b0, dt_mag_ff};
         end
         ST_MUL_P: begin
            mul_a = {1'b0, gp_mag_ff};
            mul_b = p_meas_ff ? din_mag_ff : {1'b0, err_mag_ff};
         end
         ST_MUL_D: begin
            mul_a = {1'b0, gd_mag_ff};
            mul_b = d_meas_ff ? din_mag_ff : diff_mag_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   // term clipping input: gain products drop 16 fraction bits, the time product does not
   always_comb begin
      case (state_ff)
         ST_FIN_I, ST_FIN_P: fin_val = {{(MAG_W-PROD_W+FRAC_W){1'b0}},
                                        prod_ff[PROD_W-1:FRAC_W]};
         ST_FIN_D:           fin_val = {{FRAC_W{1'b0}}, mag_ff[MAG_W-1:FRAC_W]};
         default:            fin_val = mag_ff;
      endcase
   end

   assign fin = fin_term(fin_val, neg_ff);

   always_comb begin
      case (state_ff)
         ST_ADD_P: begin
            add_a   = integ_ff;
            add_sub = tneg_ff ^ p_meas_ff;
         end
         ST_ADD_D: begin
            add_a   = res_ff;
            add_sub = tneg_ff ^ d_meas_ff;
         end
         default: begin
            add_a   = integ_ff;
            add_sub = tneg_ff;
         end
      endcase
   end

   assign sum = acc_addsub(add_a, tmag_ff, add_sub);

   // restoring divider step: shift one dividend bit into the remainder
   assign div_trial = {rem_ff, mag_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= dt_mag_ff);
   assign div_rest  = div_trial - dt_mag_ff;

   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      p_meas_in    = p_meas_ff;
      d_meas_in    = d_meas_ff;
      prev_meas_in = prev_meas_ff;
      prev_err_in  = prev_err_ff;
      prev_time_in = prev_time_ff;
      integ_in     = integ_ff;
      rsp_valid_in = rsp_valid_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;
      ts_in        = ts_ff;
      din_in       = din_ff;
      diff_in      = diff_ff;
      dt_in        = dt_ff;
      err_mag_in   = err_mag_ff;
      din_mag_in   = din_mag_ff;
      diff_mag_in  = diff_mag_ff;
      dt_mag_in    = dt_mag_ff;
      gp_mag_in    = gp_mag_ff;
      gi_mag_in    = gi_mag_ff;
      gd_mag_in    = gd_mag_ff;
      neg_in       = neg_ff;
      tneg_in      = tneg_ff;
      tmag_in      = tmag_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      sat_in       = sat_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_P:    gain_p_in = csr_wdata;
            CSR_GAIN_I:    gain_i_in = csr_wdata;
            CSR_GAIN_D:    gain_d_in = csr_wdata;
            CSR_P_ON_MEAS: p_meas_in = csr_wdata[0];
            CSR_D_ON_MEAS: d_meas_in = csr_wdata[0];
            default: ;
         endcase
      end

      // drop the result once it transfers
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               meas_in = req_measurement;
               err_in  = err_clip;
               ts_in   = req_timestamp;
               if (req_operation == OP_OBSERVE) begin
                  prev_meas_in = req_measurement;
                  prev_err_in  = err_clip;
                  prev_time_in = req_timestamp;
               end else begin
                  sat_in   = 1'b0;
                  state_in = ST_PREP;
                  // seed the history on the first compute sample
                  if (!primed_ff) begin
                     prev_meas_in = req_measurement;
                     prev_err_in  = err_clip;
                     prev_time_in = req_timestamp;
                     integ_in     = '0;
                     primed_in    = 1'b1;
                  end
               end
            end
         end
         ST_PREP: begin
            din_in       = {meas_ff[VALUE_W-1], meas_ff}
                         - {prev_meas_ff[VALUE_W-1], prev_meas_ff};
            diff_in      = {err_ff[VALUE_W-1], err_ff}
                         - {prev_err_ff[VALUE_W-1], prev_err_ff};
            dt_in        = ts_ff - prev_time_ff;
            prev_meas_in = meas_ff;
            prev_err_in  = err_ff;
            prev_time_in = ts_ff;
            state_in     = ST_ABS;
         end
         ST_ABS: begin
            err_mag_in  = err_ff[VALUE_W-1] ? (~err_ff + 1'b1) : err_ff;
            din_mag_in  = din_ff[VALUE_W] ? (~din_ff + 1'b1) : din_ff;
            diff_mag_in = diff_ff[VALUE_W] ? (~diff_ff + 1'b1) : diff_ff;
            dt_mag_in   = dt_ff[TIME_W-1] ? (~dt_ff + 1'b1) : dt_ff;
            gp_mag_in   = gain_p_ff[VALUE_W-1] ? (~gain_p_ff + 1'b1) : gain_p_ff;
            gi_mag_in   = gain_i_ff[VALUE_W-1] ? (~gain_i_ff + 1'b1) : gain_i_ff;
            gd_mag_in   = gain_d_ff[VALUE_W-1] ? (~gain_d_ff + 1'b1) : gain_d_ff;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            prod_in  = mul_out;
            neg_in   = gain_i_ff[VALUE_W-1] ^ err_ff[VALUE_W-1];
            state_in = ST_FIN_I;
         end
         ST_FIN_I: begin
            tmag_in  = fin.mag;
            tneg_in  = neg_ff;
            sat_in   = sat_ff | fin.sat;
            state_in = ST_MUL_TL;
         end
         ST_MUL_TL: begin
            prod_in  = mul_out;
            neg_in   = tneg_ff ^ dt_ff[TIME_W-1];
            state_in = ST_MUL_TH;
         end
         ST_MUL_TH: begin
            mag_in   = {{(MAG_W-PROD_W){1'b0}}, prod_ff};
            prod_in  = mul_out;
            state_in = ST_ACC_T;
         end
         ST_ACC_T: begin
            mag_in   = mag_ff + {prod_ff[MAG_W-OPND_W-1:0], {OPND_W{1'b0}}};
            state_in = ST_FIN_T;
         end
         ST_FIN_T: begin
            tmag_in  = fin.mag;
            tneg_in  = neg_ff;
            sat_in   = sat_ff | fin.sat;
            state_in = ST_ADD_I;
         end
         ST_ADD_I: begin
            integ_in = sum.val;
            sat_in   = sat_ff | sum.sat;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            prod_in  = mul_out;
            neg_in   = gain_p_ff[VALUE_W-1] ^ (p_meas_ff ? din_ff[VALUE_W] : err_ff[VALUE_W-1]);
            state_in = ST_FIN_P;
         end
         ST_FIN_P: begin
            tmag_in  = fin.mag;
            tneg_in  = neg_ff;
            sat_in   = sat_ff | fin.sat;
            state_in = ST_ADD_P;
         end
         ST_ADD_P: begin
            // on measurement the term goes into the integral, else only into the drive
            res_in = sum.val;
            sat_in = sat_ff | sum.sat;
            if (p_meas_ff) begin
               integ_in = sum.val;
            end
            state_in = dt_pos ? ST_MUL_D : ST_OUT;
         end
         ST_MUL_D: begin
            prod_in  = mul_out;
            neg_in   = gain_d_ff[VALUE_W-1] ^ (d_meas_ff ? din_ff[VALUE_W] : diff_ff[VALUE_W]);
            state_in = ST_LOAD_D;
         end
         ST_LOAD_D: begin
            mag_in   = {{(MAG_W-DIV_W){1'b0}}, prod_ff[DIV_W-1:0]};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_rest[TIME_W-2:0] : div_trial[TIME_W-2:0];
            mag_in = {mag_ff[MAG_W-1:DIV_W], mag_ff[DIV_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {CNT_W{1'b1}}) begin
               state_in = ST_FIN_D;
            end
         end
         ST_FIN_D: begin
            tmag_in  = fin.mag;
            tneg_in  = neg_ff;
            sat_in   = sat_ff | fin.sat;
            state_in = ST_ADD_D;
         end
         ST_ADD_D: begin
            res_in   = sum.val;
            sat_in   = sat_ff | sum.sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (res_fits) begin
                  rsp_drive_in = res_ff[VALUE_W-1:0];
                  rsp_sat_in   = sat_ff;
               end else begin
                  rsp_drive_in = res_ff[ACC_W-1] ? VALUE_MIN : VALUE_MAX;
                  rsp_sat_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         p_meas_ff    <= 1'b0;
         d_meas_ff    <= 1'b0;
         prev_meas_ff <= '0;
         prev_err_ff  <= '0;
         prev_time_ff <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         p_meas_ff    <= p_meas_in;
         d_meas_ff    <= d_meas_in;
         prev_meas_ff <= prev_meas_in;
         prev_err_ff  <= prev_err_in;
         prev_time_ff <= prev_time_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      err_ff       <= err_in;
      ts_ff        <= ts_in;
      din_ff       <= din_in;
      diff_ff      <= diff_in;
      dt_ff        <= dt_in;
      err_mag_ff   <= err_mag_in;
      din_mag_ff   <= din_mag_in;
      diff_mag_ff  <= diff_mag_in;
      dt_mag_ff    <= dt_mag_in;
      gp_mag_ff    <= gp_mag_in;
      gi_mag_ff    <= gi_mag_in;
      gd_mag_ff    <= gd_mag_in;
      neg_ff       <= neg_in;
      tneg_ff      <= tneg_in;
      tmag_ff      <= tmag_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      sat_ff       <= sat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   `PS_ASSERT_NEXT(a_observe_no_work, clock, reset, req_xfer && (req_operation == OP_OBSERVE),
                   (state_ff == ST_IDLE) && $stable(primed_ff))
   `PS_ASSERT_NEXT(a_compute_primes, clock, reset, req_xfer && (req_operation == OP_COMPUTE),
                   primed_ff && (state_ff == ST_PREP))
   `PS_ASSERT_NOW(a_div_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < dt_mag_ff)
   `PS_ASSERT_NEXT(a_result_loaded, clock, reset,
                   (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall),
                   rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
